@@ sv/aard_pkg.sv @@
// Shared constants, types and a helper function of the area-average RGB downscaler.
`default_nettype none
package aard_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DIM_LOG    = $clog2(MAX_DIM);
  localparam int POS_W      = DIM_LOG;
  localparam int DIM_W      = DIM_LOG + 1;
  localparam int ADDR_W     = DIM_LOG + 1;
  localparam int FRAC_W     = 4;
  localparam int EDGE_W     = DIM_LOG + 1 + FRAC_W;
  localparam int NUM_W      = 2 * DIM_LOG + 1 + FRAC_W;
  localparam int WX_W       = FRAC_W + 1;
  localparam int WT_W       = 2 * FRAC_W + 1;
  localparam int CH_W       = 8;
  localparam int RGB_W      = 3 * CH_W;
  localparam int ACC_W      = 40;
  localparam int AREA_W     = 2 * EDGE_W - 1;
  localparam int QUO_W      = CH_W + 1;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_ADDR_W = 8;
  localparam int CMP_W      = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;

  localparam logic [CFG_ADDR_W-1:0] CFG_SRC_WIDTH  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_SRC_HEIGHT = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_DST_WIDTH  = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] CFG_DST_HEIGHT = CFG_ADDR_W'(3);

  typedef struct packed {
    logic [ACC_W-1:0] red;
    logic [ACC_W-1:0] green;
    logic [ACC_W-1:0] blue;
  } acc_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_E1C,
    ST_E1CW,
    ST_E1R,
    ST_E1RW,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_EMRD,
    ST_EMST,
    ST_EMDIV,
    ST_EMWR,
    ST_UPD,
    ST_EDGE
  } state_e;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (CMP_W'(v) > CMP_W'(hi)) begin
      r = hi;
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/aard_ifs.sv @@
// Valid/ready channel interfaces for pixel input, result output and configuration writes.
`default_nettype none
interface aard_pix_if;
  logic                      valid;
  logic                      ready;
  logic [aard_pkg::RGB_W-1:0] pixel_rgb;
  modport source(output valid, output pixel_rgb, input ready);
  modport sink(input valid, input pixel_rgb, output ready);
endinterface

interface aard_res_if;
  logic                      valid;
  logic                      ready;
  logic [aard_pkg::POS_W-1:0] out_col;
  logic [aard_pkg::POS_W-1:0] out_row;
  logic [aard_pkg::RGB_W-1:0] out_rgb;
  logic                      frame_done;
  modport source(output valid, output out_col, output out_row, output out_rgb,
                 output frame_done, input ready);
  modport sink(input valid, input out_col, input out_row, input out_rgb,
               input frame_done, output ready);
endinterface

interface aard_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [aard_pkg::CFG_ADDR_W-1:0] addr;
  logic [aard_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, output addr, output data, input ready);
  modport sink(input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

@@ sv/aard_acc_mem.sv @@
// Accumulator memory: two banks of per-column RGB sums, one read and one write port.
`default_nettype none
module aard_acc_mem (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [aard_pkg::ADDR_W-1:0] waddr_i,
  input  wire aard_pkg::acc_t              wdata_i,
  input  wire logic [aard_pkg::ADDR_W-1:0] raddr_i,
  output aard_pkg::acc_t                   rdata_o
);

  aard_pkg::acc_t mem_q [2**aard_pkg::ADDR_W];
  aard_pkg::acc_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/aard_edge_div.sv @@
// Cell edge unit: floor(16*i*s/d), one multiply then one quotient bit per cycle.
`default_nettype none
module aard_edge_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [aard_pkg::DIM_W-1:0]  mul_i,
  input  wire logic [aard_pkg::DIM_W-1:0]  fac_i,
  input  wire logic [aard_pkg::DIM_W-1:0]  den_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [aard_pkg::EDGE_W-1:0]      q_o
);

  localparam int CNT_W = $clog2(aard_pkg::NUM_W);
  localparam int PRD_W = aard_pkg::NUM_W - aard_pkg::FRAC_W;

  logic                          run_q, run_d;
  logic                          done_q, done_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [aard_pkg::NUM_W-1:0]    num_q, num_d;
  logic [aard_pkg::NUM_W-1:0]    quo_q, quo_d;
  logic [aard_pkg::DIM_W-2:0]    rem_q, rem_d;
  logic [aard_pkg::DIM_W-1:0]    den_q, den_d;
  logic [2*aard_pkg::DIM_W-1:0]  prod;
  logic [aard_pkg::DIM_W-1:0]    rem_t;
  logic                          ge;

  always_comb begin
    prod   = mul_i * fac_i;
    rem_t  = {rem_q, num_q[aard_pkg::NUM_W-1]};
    ge     = rem_t >= den_q;
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(aard_pkg::NUM_W - 1);
      num_d = {prod[PRD_W-1:0], aard_pkg::FRAC_W'(0)};
      quo_d = '0;
      rem_d = '0;
      den_d = den_i;
    end else if (run_q) begin
      num_d = {num_q[aard_pkg::NUM_W-2:0], 1'b0};
      quo_d = {quo_q[aard_pkg::NUM_W-2:0], ge};
      rem_d = ge ? (aard_pkg::DIM_W-1)'(rem_t - den_q) : rem_t[aard_pkg::DIM_W-2:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = run_q;
  assign done_o = done_q;
  assign q_o    = quo_q[aard_pkg::EDGE_W-1:0];

endmodule
`default_nettype wire

@@ sv/aard_avg_div.sv @@
// Averaging unit: three channel sums divided by the cell area, one bit per cycle, clamped.
`default_nettype none
module aard_avg_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire aard_pkg::acc_t              sum_i,
  input  wire logic [aard_pkg::AREA_W-1:0] area_i,
  output logic                             done_o,
  output logic [aard_pkg::RGB_W-1:0]       rgb_o
);

  localparam int REM_W = aard_pkg::AREA_W + aard_pkg::CH_W;
  localparam int CNT_W = $clog2(aard_pkg::QUO_W);

  logic                         run_q, run_d;
  logic                         done_q, done_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [REM_W-1:0]             dvs_q, dvs_d;
  logic [REM_W-1:0]             rem_q [3];
  logic [REM_W-1:0]             rem_d [3];
  logic [aard_pkg::QUO_W-1:0]   quo_q [3];
  logic [aard_pkg::QUO_W-1:0]   quo_d [3];
  logic [REM_W-1:0]             sum_x [3];
  logic [aard_pkg::CH_W-1:0]    ch    [3];

  always_comb begin
    sum_x[0] = REM_W'(sum_i.red);
    sum_x[1] = REM_W'(sum_i.green);
    sum_x[2] = REM_W'(sum_i.blue);
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    for (int l = 0; l < 3; l++) begin
      rem_d[l] = rem_q[l];
      quo_d[l] = quo_q[l];
    end
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(aard_pkg::QUO_W - 1);
      dvs_d = {area_i, aard_pkg::CH_W'(0)};
      for (int l = 0; l < 3; l++) begin
        rem_d[l] = sum_x[l];
        quo_d[l] = '0;
      end
    end else if (run_q) begin
      dvs_d = dvs_q >> 1;
      cnt_d = cnt_q - CNT_W'(1);
      for (int l = 0; l < 3; l++) begin
        if (rem_q[l] >= dvs_q) begin
          rem_d[l] = rem_q[l] - dvs_q;
          quo_d[l] = {quo_q[l][aard_pkg::QUO_W-2:0], 1'b1};
        end else begin
          quo_d[l] = {quo_q[l][aard_pkg::QUO_W-2:0], 1'b0};
        end
      end
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
    for (int l = 0; l < 3; l++) begin
      ch[l] = quo_q[l][aard_pkg::QUO_W-1] ? '1 : quo_q[l][aard_pkg::CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    for (int l = 0; l < 3; l++) begin
      rem_q[l] <= rem_d[l];
      quo_q[l] <= quo_d[l];
    end
  end

  assign done_o = done_q;
  assign rgb_o  = {ch[0], ch[1], ch[2]};

endmodule
`default_nettype wire

@@ sv/area_average_rgb_downscaler.sv @@
// Top level of the area-average RGB downscaler: sequencer, positions, edges and result register.
// Each pixel takes four read-modify-write passes on the accumulator memory. When it finishes
// a cell, the cell sum is divided by the cell area and the result is registered, waiting while
// a previous result is not taken; an edge division follows when a destination edge moves.
// Reset and every write to a size register start a clearing pass over all 8192 accumulator
// entries, then the column and row edge setup; no pixel is taken meanwhile.
`default_nettype none
module area_average_rgb_downscaler (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  aard_pix_if.sink   pix_i,
  aard_res_if.source res_o,
  aard_cfg_if.sink   cfg_i
);

  localparam int POS_W  = aard_pkg::POS_W;
  localparam int DIM_W  = aard_pkg::DIM_W;
  localparam int EDGE_W = aard_pkg::EDGE_W;
  localparam int ADDR_W = aard_pkg::ADDR_W;
  localparam int WX_W   = aard_pkg::WX_W;
  localparam int WT_W   = aard_pkg::WT_W;
  localparam int CH_W   = aard_pkg::CH_W;
  localparam int ACC_W  = aard_pkg::ACC_W;

  aard_pkg::state_e state_q, state_d;

  logic [aard_pkg::CFG_DATA_W-1:0] src_w_q, src_w_d, src_h_q, src_h_d;
  logic [aard_pkg::CFG_DATA_W-1:0] dst_w_q, dst_w_d, dst_h_q, dst_h_d;
  logic [DIM_W-1:0]  sw, sh, dw, dh;

  logic [POS_W-1:0]  scol_q, scol_d, srow_q, srow_d, dcol_q, dcol_d, drow_q, drow_d;
  logic [EDGE_W-1:0] col_edge_q, col_edge_d, row_edge_q, row_edge_d;
  logic [EDGE_W-1:0] col_start_q, col_start_d, row_start_q, row_start_d;
  logic [EDGE_W-1:0] col_e1_q, col_e1_d, row_e1_q, row_e1_d;
  logic              axis_row_q, axis_row_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [1:0]        k_q, k_d;

  logic [aard_pkg::RGB_W-1:0] pix_q, pix_d;
  logic [WX_W-1:0]   w0_q, w0_d, w1_q, w1_d, v0_q, v0_d, v1_q, v1_d;
  logic              col_end_q, col_end_d, row_end_q, row_end_d;
  logic [WT_W-1:0]   wt_q, wt_d;
  logic [aard_pkg::AREA_W-1:0] area_q, area_d;

  logic              res_valid_q, res_valid_d;
  logic [POS_W-1:0]  res_col_q, res_col_d, res_row_q, res_row_d;
  logic [aard_pkg::RGB_W-1:0] res_rgb_q, res_rgb_d;
  logic              res_done_q, res_done_d;

  logic [EDGE_W-1:0] clo, chi, rlo, rhi, cmin, cmax, rmin, rmax;
  logic              cfg_fire, cfg_hit;
  logic [POS_W-1:0]  xb;
  logic              bank0;
  logic [ADDR_W-1:0] addr_k;
  logic              we_ok;
  logic [WX_W-1:0]   wx_k, vy_k;
  logic [2*EDGE_W-1:0] area_full;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  aard_pkg::acc_t    mem_wdata, mem_rdata;

  logic              ediv_start, ediv_busy, ediv_done;
  logic [DIM_W-1:0]  ediv_mul, ediv_fac, ediv_den;
  logic [EDGE_W-1:0] ediv_q;

  logic              adiv_start, adiv_done;
  logic [aard_pkg::RGB_W-1:0] adiv_rgb;

  aard_acc_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  aard_edge_div u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ediv_start),
    .mul_i   (ediv_mul),
    .fac_i   (ediv_fac),
    .den_i   (ediv_den),
    .busy_o  (ediv_busy),
    .done_o  (ediv_done),
    .q_o     (ediv_q)
  );

  aard_avg_div u_avg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (adiv_start),
    .sum_i   (mem_rdata),
    .area_i  (area_q),
    .done_o  (adiv_done),
    .rgb_o   (adiv_rgb)
  );

  assign sw = aard_pkg::clamp_dim(src_w_q, DIM_W'(aard_pkg::MAX_DIM));
  assign sh = aard_pkg::clamp_dim(src_h_q, DIM_W'(aard_pkg::MAX_DIM));
  assign dw = aard_pkg::clamp_dim(dst_w_q, sw);
  assign dh = aard_pkg::clamp_dim(dst_h_q, sh);

  assign pix_i.ready = (state_q == aard_pkg::ST_IDLE) && !cfg_i.valid;
  assign cfg_i.ready = !(state_q == aard_pkg::ST_RD   || state_q == aard_pkg::ST_WR   ||
                         state_q == aard_pkg::ST_EMRD || state_q == aard_pkg::ST_EMST ||
                         state_q == aard_pkg::ST_EMDIV || state_q == aard_pkg::ST_EMWR);
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign cfg_hit     = cfg_fire && (cfg_i.addr == aard_pkg::CFG_SRC_WIDTH ||
                                    cfg_i.addr == aard_pkg::CFG_SRC_HEIGHT ||
                                    cfg_i.addr == aard_pkg::CFG_DST_WIDTH ||
                                    cfg_i.addr == aard_pkg::CFG_DST_HEIGHT);

  assign res_o.valid      = res_valid_q;
  assign res_o.out_col    = res_col_q;
  assign res_o.out_row    = res_row_q;
  assign res_o.out_rgb    = res_rgb_q;
  assign res_o.frame_done = res_done_q;

  always_comb begin
    clo  = EDGE_W'({scol_q, aard_pkg::FRAC_W'(0)});
    chi  = clo + EDGE_W'(2**aard_pkg::FRAC_W);
    rlo  = EDGE_W'({srow_q, aard_pkg::FRAC_W'(0)});
    rhi  = rlo + EDGE_W'(2**aard_pkg::FRAC_W);
    cmin = (col_edge_q < chi) ? col_edge_q : chi;
    cmax = (col_edge_q > clo) ? col_edge_q : clo;
    rmin = (row_edge_q < rhi) ? row_edge_q : rhi;
    rmax = (row_edge_q > rlo) ? row_edge_q : rlo;

    xb    = dcol_q + POS_W'(1);
    bank0 = drow_q[0];
    case (k_q)
      2'd0:    begin addr_k = {bank0, dcol_q};  wx_k = w0_q; vy_k = v0_q; end
      2'd1:    begin addr_k = {~bank0, dcol_q}; wx_k = w0_q; vy_k = v1_q; end
      2'd2:    begin addr_k = {bank0, xb};      wx_k = w1_q; vy_k = v0_q; end
      default: begin addr_k = {~bank0, xb};     wx_k = w1_q; vy_k = v1_q; end
    endcase
    we_ok = !k_q[1] || (dcol_q != POS_W'(aard_pkg::MAX_DIM - 1));
    area_full = (col_edge_q - col_start_q) * (row_edge_q - row_start_q);

    state_d     = state_q;
    src_w_d     = src_w_q;
    src_h_d     = src_h_q;
    dst_w_d     = dst_w_q;
    dst_h_d     = dst_h_q;
    scol_d      = scol_q;
    srow_d      = srow_q;
    dcol_d      = dcol_q;
    drow_d      = drow_q;
    col_edge_d  = col_edge_q;
    row_edge_d  = row_edge_q;
    col_start_d = col_start_q;
    row_start_d = row_start_q;
    col_e1_d    = col_e1_q;
    row_e1_d    = row_e1_q;
    axis_row_d  = axis_row_q;
    clr_d       = clr_q;
    k_d         = k_q;
    pix_d       = pix_q;
    w0_d        = w0_q;
    w1_d        = w1_q;
    v0_d        = v0_q;
    v1_d        = v1_q;
    col_end_d   = col_end_q;
    row_end_d   = row_end_q;
    wt_d        = wt_q;
    area_d      = area_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_col_d   = res_col_q;
    res_row_d   = res_row_q;
    res_rgb_d   = res_rgb_q;
    res_done_d  = res_done_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_k;
    mem_wdata   = '0;
    mem_raddr   = addr_k;
    ediv_start  = 1'b0;
    ediv_mul    = DIM_W'(1);
    ediv_fac    = sw;
    ediv_den    = dw;
    adiv_start  = 1'b0;

    case (state_q)
      aard_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + ADDR_W'(1);
        if (&clr_q) begin
          state_d = aard_pkg::ST_E1C;
        end
      end
      aard_pkg::ST_E1C: begin
        ediv_start = 1'b1;
        state_d    = aard_pkg::ST_E1CW;
      end
      aard_pkg::ST_E1CW: begin
        if (ediv_done) begin
          col_e1_d   = ediv_q;
          col_edge_d = ediv_q;
          state_d    = aard_pkg::ST_E1R;
        end
      end
      aard_pkg::ST_E1R: begin
        ediv_start = 1'b1;
        ediv_fac   = sh;
        ediv_den   = dh;
        state_d    = aard_pkg::ST_E1RW;
      end
      aard_pkg::ST_E1RW: begin
        if (ediv_done) begin
          row_e1_d   = ediv_q;
          row_edge_d = ediv_q;
          state_d    = aard_pkg::ST_IDLE;
        end
      end
      aard_pkg::ST_IDLE: begin
        if (pix_i.valid && pix_i.ready) begin
          pix_d     = pix_i.pixel_rgb;
          w0_d      = (col_edge_q > clo) ? WX_W'(cmin - clo) : '0;
          w1_d      = (col_edge_q < chi) ? WX_W'(chi - cmax) : '0;
          v0_d      = (row_edge_q > rlo) ? WX_W'(rmin - rlo) : '0;
          v1_d      = (row_edge_q < rhi) ? WX_W'(rhi - rmax) : '0;
          col_end_d = col_edge_q <= chi;
          row_end_d = row_edge_q <= rhi;
          k_d       = '0;
          state_d   = aard_pkg::ST_RD;
        end
      end
      aard_pkg::ST_RD: begin
        wt_d    = WT_W'(wx_k * vy_k);
        state_d = aard_pkg::ST_WR;
      end
      aard_pkg::ST_WR: begin
        mem_we          = we_ok;
        mem_wdata.red   = mem_rdata.red   + ACC_W'(pix_q[3*CH_W-1:2*CH_W] * wt_q);
        mem_wdata.green = mem_rdata.green + ACC_W'(pix_q[2*CH_W-1:CH_W] * wt_q);
        mem_wdata.blue  = mem_rdata.blue  + ACC_W'(pix_q[CH_W-1:0] * wt_q);
        k_d             = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = (col_end_q && row_end_q) ? aard_pkg::ST_EMRD : aard_pkg::ST_UPD;
        end else begin
          state_d = aard_pkg::ST_RD;
        end
      end
      aard_pkg::ST_EMRD: begin
        mem_raddr = {bank0, dcol_q};
        area_d    = area_full[aard_pkg::AREA_W-1:0];
        state_d   = aard_pkg::ST_EMST;
      end
      aard_pkg::ST_EMST: begin
        adiv_start = 1'b1;
        state_d    = aard_pkg::ST_EMDIV;
      end
      aard_pkg::ST_EMDIV: begin
        if (adiv_done) begin
          state_d = aard_pkg::ST_EMWR;
        end
      end
      aard_pkg::ST_EMWR: begin
        if (!res_valid_q || res_o.ready) begin
          mem_we      = 1'b1;
          mem_waddr   = {bank0, dcol_q};
          res_valid_d = 1'b1;
          res_col_d   = dcol_q;
          res_row_d   = drow_q;
          res_rgb_d   = adiv_rgb;
          res_done_d  = (DIM_W'(dcol_q) + DIM_W'(1) == dw) &&
                        (DIM_W'(drow_q) + DIM_W'(1) == dh);
          state_d     = aard_pkg::ST_UPD;
        end
      end
      aard_pkg::ST_UPD: begin
        state_d = aard_pkg::ST_IDLE;
        if (DIM_W'(scol_q) + DIM_W'(1) >= sw) begin
          scol_d      = '0;
          dcol_d      = '0;
          col_edge_d  = col_e1_q;
          col_start_d = '0;
          if (DIM_W'(srow_q) + DIM_W'(1) >= sh) begin
            srow_d      = '0;
            drow_d      = '0;
            row_edge_d  = row_e1_q;
            row_start_d = '0;
          end else begin
            srow_d = srow_q + POS_W'(1);
            if (row_end_q && (DIM_W'(drow_q) + DIM_W'(1) < dh)) begin
              drow_d      = drow_q + POS_W'(1);
              row_start_d = row_edge_q;
              ediv_start  = 1'b1;
              ediv_mul    = DIM_W'(drow_q) + DIM_W'(2);
              ediv_fac    = sh;
              ediv_den    = dh;
              axis_row_d  = 1'b1;
              state_d     = aard_pkg::ST_EDGE;
            end
          end
        end else begin
          scol_d = scol_q + POS_W'(1);
          if (col_end_q && (DIM_W'(dcol_q) + DIM_W'(1) < dw)) begin
            dcol_d      = dcol_q + POS_W'(1);
            col_start_d = col_edge_q;
            ediv_start  = 1'b1;
            ediv_mul    = DIM_W'(dcol_q) + DIM_W'(2);
            axis_row_d  = 1'b0;
            state_d     = aard_pkg::ST_EDGE;
          end
        end
      end
      aard_pkg::ST_EDGE: begin
        if (ediv_done) begin
          if (axis_row_q) begin
            row_edge_d = ediv_q;
          end else begin
            col_edge_d = ediv_q;
          end
          state_d = aard_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = aard_pkg::ST_CLEAR;
        clr_d   = '0;
      end
    endcase

    if (cfg_hit) begin
      case (cfg_i.addr)
        aard_pkg::CFG_SRC_WIDTH:  src_w_d = cfg_i.data;
        aard_pkg::CFG_SRC_HEIGHT: src_h_d = cfg_i.data;
        aard_pkg::CFG_DST_WIDTH:  dst_w_d = cfg_i.data;
        default:                  dst_h_d = cfg_i.data;
      endcase
      state_d     = aard_pkg::ST_CLEAR;
      clr_d       = '0;
      scol_d      = '0;
      srow_d      = '0;
      dcol_d      = '0;
      drow_d      = '0;
      col_start_d = '0;
      row_start_d = '0;
      ediv_start  = 1'b0;
      adiv_start  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aard_pkg::ST_CLEAR;
      src_w_q     <= aard_pkg::CFG_DATA_W'(1);
      src_h_q     <= aard_pkg::CFG_DATA_W'(1);
      dst_w_q     <= aard_pkg::CFG_DATA_W'(1);
      dst_h_q     <= aard_pkg::CFG_DATA_W'(1);
      scol_q      <= '0;
      srow_q      <= '0;
      dcol_q      <= '0;
      drow_q      <= '0;
      col_edge_q  <= '0;
      row_edge_q  <= '0;
      col_start_q <= '0;
      row_start_q <= '0;
      col_e1_q    <= '0;
      row_e1_q    <= '0;
      axis_row_q  <= 1'b0;
      clr_q       <= '0;
      k_q         <= '0;
      col_end_q   <= 1'b0;
      row_end_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      src_w_q     <= src_w_d;
      src_h_q     <= src_h_d;
      dst_w_q     <= dst_w_d;
      dst_h_q     <= dst_h_d;
      scol_q      <= scol_d;
      srow_q      <= srow_d;
      dcol_q      <= dcol_d;
      drow_q      <= drow_d;
      col_edge_q  <= col_edge_d;
      row_edge_q  <= row_edge_d;
      col_start_q <= col_start_d;
      row_start_q <= row_start_d;
      col_e1_q    <= col_e1_d;
      row_e1_q    <= row_e1_d;
      axis_row_q  <= axis_row_d;
      clr_q       <= clr_d;
      k_q         <= k_d;
      col_end_q   <= col_end_d;
      row_end_q   <= row_end_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q     <= pix_d;
    w0_q      <= w0_d;
    w1_q      <= w1_d;
    v0_q      <= v0_d;
    v1_q      <= v1_d;
    wt_q      <= wt_d;
    area_q    <= area_d;
    res_col_q <= res_col_d;
    res_row_q <= res_row_d;
    res_rgb_q <= res_rgb_d;
    res_done_q <= res_done_d;
  end

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (DIM_W'(scol_q) < sw) && (DIM_W'(dcol_q) < dw) &&
    (DIM_W'(srow_q) < sh) && (DIM_W'(drow_q) < dh))
    else $error("position beyond frame size");

  a_idle_edge_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aard_pkg::ST_IDLE) |-> !ediv_busy)
    else $error("pixel taken while edge unit busy");

  a_cell_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aard_pkg::ST_IDLE) |-> (col_start_q < col_edge_q) &&
                                       (row_start_q < row_edge_q))
    else $error("empty destination cell");
`endif

endmodule
`default_nettype wire
